@@ rtl/pidfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pidfd_pkg
// Shared widths, codes and helper types for the filtered-derivative PID unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pidfd_pkg;

    localparam int DATA_W    = 32;
    localparam int Q_FRAC    = 16;
    localparam int MUL_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int RND_W     = PROD_W - Q_FRAC;
    localparam int ACC_W     = RND_W + 1;
    localparam int COEF_W    = DATA_W - 1;
    localparam int AB_W      = 2 * DATA_W - Q_FRAC;
    localparam int NUM_W     = AB_W + 4;
    localparam int DEN_W     = AB_W + 3;
    localparam int DIV_W     = COEF_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0]   SAMPLE_TIME_RESET = DATA_W'(328);
    localparam logic [PROD_W-1:0]   RND_HALF          = PROD_W'(1) << (Q_FRAC - 1);
    localparam logic [DEN_W-1:0]    DEN_ONE           = DEN_W'(1) << Q_FRAC;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT     = DIV_CNT_W'(DIV_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_TIME = 3'd0,
        CFG_CUTOFF      = 3'd1,
        CFG_GAIN_P      = 3'd2,
        CFG_GAIN_I      = 3'd3,
        CFG_GAIN_D      = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_CI,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_P,
        ST_MUL_IT,
        ST_CAP_INT,
        ST_DIV_SETUP,
        ST_DIV_RUN,
        ST_MUL_DT,
        ST_CAP_DER,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_GI_T,
        MUL_GD_WC,
        MUL_T_WC,
        MUL_GP_E,
        MUL_CI_S,
        MUL_G_D
    } mul_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_CI,
        CAP_A,
        CAP_B,
        CAP_P,
        CAP_INT,
        CAP_DER
    } cap_sel_t;

    typedef struct packed {
        logic     accept;
        mul_sel_t mul_sel;
        cap_sel_t cap_sel;
        logic     div_start;
        logic     div_step;
        logic     out_load;
    } pidfd_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } pidfd_status_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-DATA_W:0] top;
        top = x[ACC_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
            sat32 = x[DATA_W-1:0];
        end else if (x[ACC_W-1]) begin
            sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat32 = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/pid_controller_filtered_derivative_unit.sv @@
// ----------------------------------------------------------------------------
// pid_controller_filtered_derivative_unit
// PID controller, trapezoidal integral and filtered derivative, Q16.16.
//
// Input: s_tvalid/s_tready/s_tdata carry one signed Q16.16 error sample per
// transaction. Output: m_tvalid/m_tready/m_tdata carry the saturated P+I+D
// drive value, one per input transaction, in order.
// Gains, sample period and filter corner are written through cfg_wr_en,
// cfg_addr and cfg_wdata; the user must do so only while the unit is idle,
// as the unit itself does not enforce it. One sample goes from input to
// output through five shared-multiplier passes for coefficients and P and I
// terms, a 31-step restoring divide for the derivative gain, one more
// multiply and the output load. A new sample is taken once the previous one
// has reached the output register.
// A stalled receiver holds m_tdata; the next sample may be taken and worked
// on meanwhile, and waits before its output load until the register frees.
// Reset clears the stored terms and the previous error and restores the
// register defaults (sample period 328, everything else zero).
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_filtered_derivative_unit (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_wr_en,
    input  wire  [pidfd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire  [pidfd_pkg::DATA_W-1:0]    cfg_wdata,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [pidfd_pkg::DATA_W-1:0]    s_tdata,   // error_sample
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [pidfd_pkg::DATA_W-1:0]    m_tdata    // drive_value
);
    import pidfd_pkg::*;

    pidfd_cmd_t    cmd;
    pidfd_status_t status;

    pidfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pidfd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

@@ rtl/pidfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// pidfd_ctrl
// Sequencer stepping the datapath through multiplies, divide and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module pidfd_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  pidfd_pkg::pidfd_status_t status,
    output pidfd_pkg::pidfd_cmd_t    cmd
);
    import pidfd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL_CI;
                end
            end
            ST_MUL_CI:    state_next = ST_MUL_A;
            ST_MUL_A:     state_next = ST_MUL_B;
            ST_MUL_B:     state_next = ST_MUL_P;
            ST_MUL_P:     state_next = ST_MUL_IT;
            ST_MUL_IT:    state_next = ST_CAP_INT;
            ST_CAP_INT:   state_next = ST_DIV_SETUP;
            ST_DIV_SETUP: state_next = ST_DIV_RUN;
            ST_DIV_RUN: begin
                if (status.div_last) begin
                    state_next = ST_MUL_DT;
                end
            end
            ST_MUL_DT:    state_next = ST_CAP_DER;
            ST_CAP_DER:   state_next = ST_OUT;
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.mul_sel   = MUL_NONE;
        cmd.cap_sel   = CAP_NONE;
        cmd.div_start = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_MUL_CI: begin
                cmd.mul_sel = MUL_GI_T;
            end
            ST_MUL_A: begin
                cmd.mul_sel = MUL_GD_WC;
                cmd.cap_sel = CAP_CI;
            end
            ST_MUL_B: begin
                cmd.mul_sel = MUL_T_WC;
                cmd.cap_sel = CAP_A;
            end
            ST_MUL_P: begin
                cmd.mul_sel = MUL_GP_E;
                cmd.cap_sel = CAP_B;
            end
            ST_MUL_IT: begin
                cmd.mul_sel = MUL_CI_S;
                cmd.cap_sel = CAP_P;
            end
            ST_CAP_INT: begin
                cmd.cap_sel = CAP_INT;
            end
            ST_DIV_SETUP: begin
                cmd.div_start = 1'b1;
            end
            ST_DIV_RUN: begin
                cmd.div_step = 1'b1;
            end
            ST_MUL_DT: begin
                cmd.mul_sel = MUL_G_D;
            end
            ST_CAP_DER: begin
                cmd.cap_sel = CAP_DER;
            end
            ST_OUT: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/pidfd_datapath.sv @@
// ----------------------------------------------------------------------------
// pidfd_datapath
// Config registers, shared multiplier, radix-2 divider, terms and output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module pidfd_datapath (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire  [pidfd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire  [pidfd_pkg::DATA_W-1:0]     cfg_wdata,
    input  wire  [pidfd_pkg::DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [pidfd_pkg::DATA_W-1:0]     m_tdata,
    input  pidfd_pkg::pidfd_cmd_t            cmd,
    output pidfd_pkg::pidfd_status_t         status
);
    import pidfd_pkg::*;

    // configuration
    logic [DATA_W-1:0] sample_time_reg;
    logic [DATA_W-1:0] cutoff_reg;
    logic [DATA_W-1:0] gain_p_reg;
    logic [DATA_W-1:0] gain_i_reg;
    logic [DATA_W-1:0] gain_d_reg;

    // controller state
    logic signed [DATA_W-1:0] integral_reg;
    logic signed [DATA_W-1:0] derivative_reg;
    logic signed [DATA_W-1:0] prev_err_reg;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;

    // per-sample working registers
    logic signed [DATA_W-1:0] err_reg;
    logic signed [MUL_W-1:0]  sum_reg;
    logic signed [MUL_W-1:0]  diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [COEF_W-1:0]        ci_reg;
    logic [AB_W-1:0]          a_reg;
    logic [AB_W-1:0]          b_reg;
    logic signed [RND_W-1:0]  p_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         quo_reg;
    logic                     ovf_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic [DATA_W-1:0]        m_tdata_reg;

    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_half;
    logic signed [RND_W-1:0]  rnd_val;
    logic signed [ACC_W-1:0]  int_sum;
    logic signed [ACC_W-1:0]  der_sum;
    logic signed [ACC_W-1:0]  total_sum;
    logic [COEF_W-1:0]        ci_next;
    logic [COEF_W-1:0]        g_coef;
    logic [NUM_W-1:0]         num_next;
    logic [DEN_W-1:0]         den_next;
    logic [DEN_W:0]           rem_shift;
    logic [DEN_W:0]           rem_diff;
    logic                     quo_bit;
    logic signed [MUL_W-1:0]  err_ext;
    logic signed [MUL_W-1:0]  prev_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_time_reg <= SAMPLE_TIME_RESET;
            cutoff_reg      <= '0;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SAMPLE_TIME: sample_time_reg <= cfg_wdata;
                CFG_CUTOFF:      cutoff_reg      <= cfg_wdata;
                CFG_GAIN_P:      gain_p_reg      <= cfg_wdata;
                CFG_GAIN_I:      gain_i_reg      <= cfg_wdata;
                CFG_GAIN_D:      gain_d_reg      <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            MUL_GI_T: begin
                op_a = {1'b0, gain_i_reg};
                op_b = {1'b0, sample_time_reg};
            end
            MUL_GD_WC: begin
                op_a = {1'b0, gain_d_reg};
                op_b = {1'b0, cutoff_reg};
            end
            MUL_T_WC: begin
                op_a = {1'b0, sample_time_reg};
                op_b = {1'b0, cutoff_reg};
            end
            MUL_GP_E: begin
                op_a = {1'b0, gain_p_reg};
                op_b = {err_reg[DATA_W-1], err_reg};
            end
            MUL_CI_S: begin
                op_a = {2'b00, ci_reg};
                op_b = sum_reg;
            end
            MUL_G_D: begin
                op_a = {2'b00, g_coef};
                op_b = diff_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);
    assign prod_half = prod_reg + signed'(RND_HALF);
    assign rnd_val   = prod_half[PROD_W-1:Q_FRAC];

    assign ci_next  = (|prod_reg[2*DATA_W-1:AB_W]) ? {COEF_W{1'b1}}
                                                   : prod_reg[AB_W-1:Q_FRAC+1];
    assign num_next = (NUM_W'(a_reg) << 3) + (NUM_W'(a_reg) << 1);
    assign den_next = (DEN_W'(b_reg) << 2) + DEN_W'(b_reg) + DEN_ONE;

    assign int_sum = {{(ACC_W-DATA_W){integral_reg[DATA_W-1]}}, integral_reg}
                   + {rnd_val[RND_W-1], rnd_val};
    assign der_sum = {{(ACC_W-DATA_W){derivative_reg[DATA_W-1]}}, derivative_reg}
                   + {rnd_val[RND_W-1], rnd_val};
    assign total_sum = {p_reg[RND_W-1], p_reg}
                     + {{(ACC_W-DATA_W){integral_reg[DATA_W-1]}}, integral_reg}
                     + {{(ACC_W-DATA_W){derivative_reg[DATA_W-1]}}, derivative_reg};

    // restoring divider step
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign quo_bit   = (rem_shift >= {1'b0, den_reg});
    assign g_coef    = ovf_reg ? {COEF_W{1'b1}} : quo_reg;

    assign err_ext  = {s_tdata[DATA_W-1], s_tdata};
    assign prev_ext = {prev_err_reg[DATA_W-1], prev_err_reg};

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.accept) begin
            err_reg  <= s_tdata;
            sum_reg  <= err_ext + prev_ext;
            diff_reg <= err_ext - prev_ext;
        end
        case (cmd.cap_sel)
            CAP_CI:  ci_reg <= ci_next;
            CAP_A:   a_reg  <= prod_reg[2*DATA_W-1:Q_FRAC];
            CAP_B:   b_reg  <= prod_reg[2*DATA_W-1:Q_FRAC];
            CAP_P:   p_reg  <= rnd_val;
            CAP_INT: begin
                num_reg <= num_next;
                den_reg <= den_next;
            end
            default: ;
        endcase
        if (cmd.div_start) begin
            ovf_reg     <= ((DEN_W+15)'(num_reg) >= {den_reg, 15'b0});
            rem_reg     <= DEN_W'(num_reg[NUM_W-1:15]);
            quo_reg     <= {num_reg[14:0], {Q_FRAC{1'b0}}};
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= quo_bit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_reg     <= {quo_reg[DIV_W-2:0], quo_bit};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.out_load) begin
            m_tdata_reg <= sat32(total_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg   <= '0;
            derivative_reg <= '0;
            prev_err_reg   <= '0;
        end else begin
            if (cmd.cap_sel == CAP_INT) begin
                integral_reg <= sat32(int_sum);
            end
            if (cmd.cap_sel == CAP_DER) begin
                derivative_reg <= sat32(der_sum);
            end
            if (cmd.out_load) begin
                prev_err_reg <= err_reg;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign status.div_last = (div_cnt_reg == DIV_LAST_CNT);
    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

`default_nettype wire
